// ===== hw/rtl/obi_pkg.sv =====
package obi_pkg;

  localparam int CW = 32;
  localparam int PW = 64;
  localparam int NW = 68;
  localparam int QW = 32;
  localparam int SW = 66;
  localparam int WFRAC = 24;
  localparam int DS = 32;

  typedef struct packed {
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bx;
    logic signed [CW-1:0] by;
    logic signed [CW-1:0] bz;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [CW-1:0] cz;
  } tri_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [NW-1:0] den;
    logic [7:0]    nlo;
    logic [QW-1:0] q;
    logic          neg;
    logic          ovf;
  } div_t;

  localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW-1){1'b0}}};

  function automatic div_t div_init(logic signed [NW-1:0] num, logic signed [NW-1:0] den);
    logic [NW-1:0] nm;
    logic [NW-1:0] dm;
    div_t r;
    nm = num[NW-1] ? NW'(-num) : NW'(num);
    dm = den[NW-1] ? NW'(-den) : NW'(den);
    r.rem = nm >> 8;
    r.nlo = nm[7:0];
    r.den = dm;
    r.q   = '0;
    r.neg = num[NW-1] ^ den[NW-1];
    r.ovf = {8'b0, nm} >= {dm, 8'b0};
    return r;
  endfunction

  function automatic div_t div_step(div_t d);
    logic [NW-1:0] t;
    logic          ge;
    div_t r;
    r  = d;
    t  = {d.rem[NW-2:0], d.nlo[7]};
    ge = t >= d.den;
    r.rem = ge ? t - d.den : t;
    r.nlo = {d.nlo[6:0], 1'b0};
    r.q   = {d.q[QW-2:0], ge};
    return r;
  endfunction

  function automatic logic signed [CW-1:0] sat_w(div_t d);
    logic signed [CW-1:0] r;
    if (d.ovf) begin
      r = d.neg ? SMIN : SMAX;
    end else if (d.neg) begin
      r = (d.q[QW-1] && (d.q[QW-2:0] != '0)) ? SMIN : CW'(-d.q);
    end else begin
      r = d.q[QW-1] ? SMAX : CW'(d.q);
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] interp(logic signed [PW-1:0] p0,
                                                  logic signed [PW-1:0] p1,
                                                  logic signed [PW-1:0] p2);
    logic signed [SW-1:0] s;
    logic signed [CW-1:0] r;
    s = SW'(p0) + SW'(p1) + SW'(p2);
    if (s[SW-1:WFRAC+CW-1] == '0 || s[SW-1:WFRAC+CW-1] == '1) begin
      r = s[WFRAC+CW-1:WFRAC];
    end else begin
      r = s[SW-1] ? SMIN : SMAX;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/origin_barycentric_interpolator.sv =====
// channel | signals                              | direction
// input   | in_valid, in_ready, a_x .. c_z       | triangle item in
// output  | out_valid, out_ready, weight_a .. degenerate | result item out
//
// One item per cycle unless the output stalls; the 32-stage restoring
// divider (one quotient bit per stage) lies between 3 front and 3 back stages.
// Reset clears the stage valid bits only.
// A stall at the output freezes every stage at once; in_ready follows it.
module origin_barycentric_interpolator (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [obi_pkg::CW-1:0]    a_x,
  input  logic signed [obi_pkg::CW-1:0]    a_y,
  input  logic signed [obi_pkg::CW-1:0]    a_z,
  input  logic signed [obi_pkg::CW-1:0]    b_x,
  input  logic signed [obi_pkg::CW-1:0]    b_y,
  input  logic signed [obi_pkg::CW-1:0]    b_z,
  input  logic signed [obi_pkg::CW-1:0]    c_x,
  input  logic signed [obi_pkg::CW-1:0]    c_y,
  input  logic signed [obi_pkg::CW-1:0]    c_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [obi_pkg::CW-1:0]    weight_a,
  output logic signed [obi_pkg::CW-1:0]    weight_b,
  output logic signed [obi_pkg::CW-1:0]    weight_c,
  output logic signed [obi_pkg::CW-1:0]    new_x,
  output logic signed [obi_pkg::CW-1:0]    new_y,
  output logic signed [obi_pkg::CW-1:0]    new_z,
  output logic                             degenerate
);
  import obi_pkg::*;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: cross-product terms
  logic                 v1;
  tri_t                 t1;
  logic signed [PW-1:0] p1 [0:5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      t1    <= '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z};
      p1[0] <= b_y * c_z;
      p1[1] <= b_z * c_y;
      p1[2] <= a_z * c_y;
      p1[3] <= a_y * c_z;
      p1[4] <= a_y * b_z;
      p1[5] <= a_z * b_y;
    end
  end

  // stage 2: numerators and determinant
  logic                 v2;
  tri_t                 t2;
  logic signed [NW-1:0] n2 [0:2];
  logic signed [NW-1:0] d2;
  logic signed [NW-1:0] na, nb, nc;

  always_comb begin
    na = NW'(p1[0]) - NW'(p1[1]);
    nb = NW'(p1[2]) - NW'(p1[3]);
    nc = NW'(p1[4]) - NW'(p1[5]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      t2    <= t1;
      n2[0] <= na;
      n2[1] <= nb;
      n2[2] <= nc;
      d2    <= na + nb + nc;
    end
  end

  // stage 3 and divider stages
  logic [DS:0] vd;
  tri_t        td [0:DS];
  logic        zd [0:DS];
  div_t        dv [0:DS][0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      vd[0] <= 1'b0;
    end else if (en) begin
      vd[0] <= v2;
    end
    if (en) begin
      td[0] <= t2;
      zd[0] <= (d2 == '0);
      for (int j = 0; j < 3; j++) begin
        dv[0][j] <= div_init(n2[j], d2);
      end
    end
  end

  for (genvar k = 1; k <= DS; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        vd[k] <= 1'b0;
      end else if (en) begin
        vd[k] <= vd[k-1];
      end
      if (en) begin
        td[k] <= td[k-1];
        zd[k] <= zd[k-1];
        for (int j = 0; j < 3; j++) begin
          dv[k][j] <= div_step(dv[k-1][j]);
        end
      end
    end
  end

  // stage 4: saturated weights
  logic                 v4;
  tri_t                 t4;
  logic                 z4;
  logic signed [CW-1:0] w4 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vd[DS];
    end
    if (en) begin
      t4 <= td[DS];
      z4 <= zd[DS];
      for (int j = 0; j < 3; j++) begin
        w4[j] <= zd[DS] ? '0 : sat_w(dv[DS][j]);
      end
    end
  end

  // stage 5: weighted vertex terms
  logic                 v5;
  logic                 z5;
  logic signed [CW-1:0] w5 [0:2];
  logic signed [PW-1:0] q5 [0:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      z5    <= z4;
      w5    <= w4;
      q5[0] <= t4.ax * w4[0];
      q5[1] <= t4.bx * w4[1];
      q5[2] <= t4.cx * w4[2];
      q5[3] <= t4.ay * w4[0];
      q5[4] <= t4.by * w4[1];
      q5[5] <= t4.cy * w4[2];
      q5[6] <= t4.az * w4[0];
      q5[7] <= t4.bz * w4[1];
      q5[8] <= t4.cz * w4[2];
    end
  end

  // stage 6: output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
    if (en) begin
      weight_a   <= w5[0];
      weight_b   <= w5[1];
      weight_c   <= w5[2];
      new_x      <= interp(q5[0], q5[1], q5[2]);
      new_y      <= interp(q5[3], q5[4], q5[5]);
      new_z      <= interp(q5[6], q5[7], q5[8]);
      degenerate <= z5;
    end
  end

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> weight_a == '0 && weight_b == '0 && weight_c == '0
      && new_x == '0 && new_y == '0 && new_z == '0)
    else $error("degenerate result not zero");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !v1 && !vd[0])
    else $error("pipeline not empty after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

endmodule
